[design/opwfd_pkg.sv]
// ----------------------------------------------------------------------------
// OOK pulse-width frame decoder package
// Shared types, register indexes, status codes and reset values.
// ----------------------------------------------------------------------------
package opwfd_pkg;

    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 3;

    localparam int FIFO_AW    = 2;
    localparam int FIFO_DEPTH = 1 << FIFO_AW;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_PREAMBLE_MIN = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PREAMBLE_MAX = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PERIOD_MIN   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PERIOD_MAX   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_BYTES    = 3'd4;

    localparam logic [14:0] PREAMBLE_MIN_RESET = 15'd2300;
    localparam logic [14:0] PREAMBLE_MAX_RESET = 15'd2600;
    localparam logic [15:0] PERIOD_MIN_RESET   = 16'd800;
    localparam logic [15:0] PERIOD_MAX_RESET   = 16'd1100;
    localparam logic [7:0]  MAX_BYTES_RESET    = 8'd255;

    // Symbols counted per frame saturate here; fewer than this is a short frame.
    localparam logic [2:0] MIN_SYMBOLS = 3'd4;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_BAD_PERIOD  = 3'd1,
        ST_LIMIT       = 3'd2,
        ST_NO_PREAMBLE = 3'd3,
        ST_SHORT       = 3'd4
    } status_t;

    typedef enum logic {
        KIND_DATA = 1'b0,
        KIND_END  = 1'b1
    } kind_t;

    typedef struct packed {
        logic [14:0] preamble_min;
        logic [14:0] preamble_max;
        logic [15:0] period_min;
        logic [15:0] period_max;
        logic [7:0]  max_bytes;
    } cfg_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  byte_value;
        logic [7:0]  byte_total;
        status_t     status;
        logic        is_last;
    } result_t;

    // Up to two results per symbol; valid1 is only set together with valid0.
    typedef struct packed {
        logic    valid0;
        logic    valid1;
        result_t res0;
        result_t res1;
    } push_t;

endpackage

[design/opwfd_decode.sv]
// ----------------------------------------------------------------------------
// OOK pulse-width frame decoder: symbol decode
// Holds the per-frame state and turns one symbol into up to two results.
// ----------------------------------------------------------------------------
module opwfd_decode #(
    parameter int DURATION_BITS = 15
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  opwfd_pkg::cfg_t          cfg,
    input  logic                     step,
    input  logic                     first_level,
    input  logic [DURATION_BITS-1:0] first_duration,
    input  logic [DURATION_BITS-1:0] second_duration,
    input  logic                     frame_last,
    output opwfd_pkg::push_t         push
);
    import opwfd_pkg::*;

    localparam int PRE_W = (DURATION_BITS > 15) ? DURATION_BITS : 15;
    localparam int SUM_W = DURATION_BITS + 1;
    localparam int PER_W = (SUM_W > 16) ? SUM_W : 16;

    logic [2:0]               symbol_index_reg, symbol_index_next;
    logic [DURATION_BITS-1:0] held_high_reg, held_high_next;
    logic [7:0]               shift_byte_reg, shift_byte_next;
    logic [2:0]               bit_count_reg, bit_count_next;
    logic [7:0]               byte_count_reg, byte_count_next;
    status_t                  stop_code_reg, stop_code_next;

    logic [PRE_W-1:0] d0_pre;
    logic [PRE_W-1:0] pre_min;
    logic [PRE_W-1:0] pre_max;
    logic [SUM_W-1:0] sum;
    logic [PER_W-1:0] sum_ext;
    logic [PER_W-1:0] per_min;
    logic [PER_W-1:0] per_max;
    logic             preamble_ok;
    logic             period_ok;
    logic [7:0]       shifted;
    logic             byte_out;
    logic [2:0]       symbols_seen;
    result_t          data_res;
    result_t          end_res;

    assign d0_pre  = PRE_W'(first_duration);
    assign pre_min = PRE_W'(cfg.preamble_min);
    assign pre_max = PRE_W'(cfg.preamble_max);
    assign sum     = SUM_W'(held_high_reg) + SUM_W'(first_duration);
    assign sum_ext = PER_W'(sum);
    assign per_min = PER_W'(cfg.period_min);
    assign per_max = PER_W'(cfg.period_max);

    assign preamble_ok = !first_level && (d0_pre > pre_min) && (d0_pre < pre_max);
    assign period_ok   = (sum_ext < per_max) && (sum_ext > per_min);
    assign shifted     = {shift_byte_reg[6:0], held_high_reg > first_duration};

    always_comb
    begin
        shift_byte_next = shift_byte_reg;
        bit_count_next  = bit_count_reg;
        byte_count_next = byte_count_reg;
        stop_code_next  = stop_code_reg;
        byte_out        = 1'b0;

        if (stop_code_reg == ST_OK)
        begin
            if (symbol_index_reg == 3'd0)
            begin
                if (!preamble_ok)
                begin
                    stop_code_next = ST_NO_PREAMBLE;
                end
            end
            else if (symbol_index_reg >= 3'd2)
            begin
                if (period_ok)
                begin
                    shift_byte_next = shifted;
                    if (bit_count_reg == 3'd7)
                    begin
                        // A completed byte past the limit is dropped.
                        if (byte_count_reg >= cfg.max_bytes)
                        begin
                            stop_code_next = ST_LIMIT;
                        end
                        else
                        begin
                            byte_count_next = byte_count_reg + 8'd1;
                            byte_out        = 1'b1;
                            shift_byte_next = 8'd0;
                            bit_count_next  = 3'd0;
                        end
                    end
                    else
                    begin
                        bit_count_next = bit_count_reg + 3'd1;
                    end
                end
                else
                begin
                    stop_code_next = ST_BAD_PERIOD;
                end
            end
        end

        symbols_seen = (symbol_index_reg < MIN_SYMBOLS) ? symbol_index_reg + 3'd1
                                                        : symbol_index_reg;
        symbol_index_next = symbols_seen;
        held_high_next    = second_duration;

        data_res.kind       = KIND_DATA;
        data_res.byte_value = shifted;
        data_res.byte_total = byte_count_next;
        data_res.status     = ST_OK;
        data_res.is_last    = 1'b0;

        end_res.kind       = KIND_END;
        end_res.byte_value = 8'd0;
        end_res.is_last    = 1'b1;
        if (symbols_seen < MIN_SYMBOLS)
        begin
            end_res.byte_total = 8'd0;
            end_res.status     = ST_SHORT;
        end
        else
        begin
            end_res.byte_total = byte_count_next;
            end_res.status     = stop_code_next;
        end

        push.valid0 = step && (byte_out || frame_last);
        push.valid1 = step && byte_out && frame_last;
        push.res0   = byte_out ? data_res : end_res;
        push.res1   = end_res;

        if (frame_last)
        begin
            symbol_index_next = 3'd0;
            held_high_next    = '0;
            shift_byte_next   = 8'd0;
            bit_count_next    = 3'd0;
            byte_count_next   = 8'd0;
            stop_code_next    = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            symbol_index_reg <= 3'd0;
            held_high_reg    <= '0;
            shift_byte_reg   <= 8'd0;
            bit_count_reg    <= 3'd0;
            byte_count_reg   <= 8'd0;
            stop_code_reg    <= ST_OK;
        end
        else if (step)
        begin
            symbol_index_reg <= symbol_index_next;
            held_high_reg    <= held_high_next;
            shift_byte_reg   <= shift_byte_next;
            bit_count_reg    <= bit_count_next;
            byte_count_reg   <= byte_count_next;
            stop_code_reg    <= stop_code_next;
        end
    end

endmodule

[design/opwfd_result_fifo.sv]
// ----------------------------------------------------------------------------
// OOK pulse-width frame decoder: result queue
// Four-entry queue that takes up to two results per cycle and sends one while out_ready is high.
// ----------------------------------------------------------------------------
module opwfd_result_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  opwfd_pkg::push_t    push,
    output logic                room,
    output logic                out_valid,
    input  logic                out_ready,
    output opwfd_pkg::result_t  head
);
    import opwfd_pkg::*;

    result_t              mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]     count_reg, count_next;
    logic [1:0]           push_count;
    logic                 pop;

    assign push_count = {1'b0, push.valid0} + {1'b0, push.valid1};
    assign out_valid  = (count_reg != '0);
    assign pop        = out_valid && out_ready;
    assign room       = (count_reg <= (FIFO_AW+1)'(FIFO_DEPTH - 2));
    assign head       = mem[rd_ptr_reg];

    assign wr_ptr_next = wr_ptr_reg + FIFO_AW'(push_count);
    assign rd_ptr_next = rd_ptr_reg + FIFO_AW'(pop);
    assign count_next  = count_reg + (FIFO_AW+1)'(push_count) - (FIFO_AW+1)'(pop);

    always_ff @(posedge clk)
    begin
        if (push.valid0)
        begin
            mem[wr_ptr_reg] <= push.res0;
        end
        if (push.valid1)
        begin
            mem[wr_ptr_reg + FIFO_AW'(1)] <= push.res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[design/ook_pulse_width_frame_decoder.sv]
// ----------------------------------------------------------------------------
// OOK pulse-width frame decoder
// Decodes captured on-off-keyed pulse symbols into data bytes and frame reports.
// ----------------------------------------------------------------------------
// The block takes one captured symbol per clock cycle. A symbol sits in an
// input register until the queue has room, is decoded by the frame state
// logic, and its results (a data byte, an end-of-frame report, or both on a
// frame's last symbol) are registered in a four-entry result queue, from
// which they are offered on the output in order. The output sends one result
// per cycle while out_ready is high; a symbol waits in the input register
// only while the queue has fewer than two free entries, so the sustained rate
// is one symbol per cycle as long as the consumer takes results at least as
// fast as they are made.
module ook_pulse_width_frame_decoder #(
    parameter int DURATION_BITS = 15
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [opwfd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [opwfd_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              first_level,
    input  logic [DURATION_BITS-1:0]          first_duration,
    input  logic [DURATION_BITS-1:0]          second_duration,
    input  logic                              frame_last,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              kind,
    output logic [7:0]                        byte_value,
    output logic [7:0]                        byte_total,
    output logic [2:0]                        status,
    output logic                              is_last
);
    import opwfd_pkg::*;

    cfg_t                     cfg_reg;
    logic                     in_valid_reg;
    logic                     level_reg;
    logic [DURATION_BITS-1:0] d0_reg;
    logic [DURATION_BITS-1:0] d1_reg;
    logic                     last_reg;
    logic                     room;
    logic                     step;
    push_t                    push;
    result_t                  head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.preamble_min <= PREAMBLE_MIN_RESET;
            cfg_reg.preamble_max <= PREAMBLE_MAX_RESET;
            cfg_reg.period_min   <= PERIOD_MIN_RESET;
            cfg_reg.period_max   <= PERIOD_MAX_RESET;
            cfg_reg.max_bytes    <= MAX_BYTES_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_PREAMBLE_MIN: cfg_reg.preamble_min <= cfg_data[14:0];
                REG_PREAMBLE_MAX: cfg_reg.preamble_max <= cfg_data[14:0];
                REG_PERIOD_MIN:   cfg_reg.period_min   <= cfg_data;
                REG_PERIOD_MAX:   cfg_reg.period_max   <= cfg_data;
                REG_MAX_BYTES:    cfg_reg.max_bytes    <= cfg_data[7:0];
                default:          ;
            endcase
        end
    end

    // The held symbol is decoded once the queue can take both of its results.
    assign step     = in_valid_reg && room;
    assign in_ready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            level_reg <= first_level;
            d0_reg    <= first_duration;
            d1_reg    <= second_duration;
            last_reg  <= frame_last;
        end
    end

    opwfd_decode #(
        .DURATION_BITS (DURATION_BITS)
    ) u_decode (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .step            (step),
        .first_level     (level_reg),
        .first_duration  (d0_reg),
        .second_duration (d1_reg),
        .frame_last      (last_reg),
        .push            (push)
    );

    opwfd_result_fifo u_result_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign kind       = head.kind;
    assign byte_value = head.byte_value;
    assign byte_total = head.byte_total;
    assign status     = head.status;
    assign is_last    = head.is_last;

endmodule

[dv/ook_pulse_width_frame_decoder_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// OOK pulse-width frame decoder testbench
// Feeds captured pulse symbols through a valid/ready driver with random gaps,
// predicts every data byte and end-of-frame report from its own decoder
// state, and checks the results field by field under random backpressure,
// across several timing-window and byte-limit settings.
// ----------------------------------------------------------------------------
module ook_pulse_width_frame_decoder_test;

    import opwfd_pkg::*;

    localparam int DW        = 15;
    localparam int DUR_MAX   = (1 << DW) - 1;
    localparam int LATENCY   = 4;
    localparam int LIMIT     = 1000000;

    typedef struct packed {
        logic          level;
        logic [DW-1:0] d0;
        logic [DW-1:0] d1;
        logic          last;
    } pulse_sym_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic                   first_level = 1'b0;
    logic [DW-1:0]          first_duration = '0;
    logic [DW-1:0]          second_duration = '0;
    logic                   frame_last = 1'b0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic                   kind;
    logic [7:0]             byte_value;
    logic [7:0]             byte_total;
    logic [2:0]             status;
    logic                   is_last;

    ook_pulse_width_frame_decoder #(
        .DURATION_BITS(DW)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .first_level    (first_level),
        .first_duration (first_duration),
        .second_duration(second_duration),
        .frame_last     (frame_last),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .byte_value     (byte_value),
        .byte_total     (byte_total),
        .status         (status),
        .is_last        (is_last)
    );

    // Decoder copy used for prediction.
    cfg_t          decode_cfg;
    logic [2:0]    sym_count  = '0;
    logic [DW-1:0] held_high  = '0;
    logic [7:0]    shift_reg  = '0;
    logic [2:0]    bits_in    = '0;
    logic [7:0]    bytes_out  = '0;
    status_t       halt_code  = ST_OK;

    pulse_sym_t symbol_backlog[$];
    result_t    expected_results[$];
    int         symbols_queued = 0;
    int         accepted_count = 0;
    int         issued_count   = 0;
    int         fail_count     = 0;
    int         cycle_count    = 0;
    bit         open_frame     = 1'b0;

    pulse_sym_t seen_sym;
    result_t    want;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    task automatic decode_symbol(input pulse_sym_t s);
        logic [16:0] period_sum;
        result_t     r;
        if (halt_code == ST_OK)
        begin
            if (sym_count == 3'd0)
            begin
                if (!(s.level == 1'b0 && s.d0 > decode_cfg.preamble_min &&
                      s.d0 < decode_cfg.preamble_max))
                    halt_code = ST_NO_PREAMBLE;
            end
            else if (sym_count >= 3'd2)
            begin
                period_sum = {2'b00, held_high} + {2'b00, s.d0};
                if (period_sum < {1'b0, decode_cfg.period_max} &&
                    period_sum > {1'b0, decode_cfg.period_min})
                begin
                    shift_reg = {shift_reg[6:0], held_high > s.d0};
                    if (bits_in >= 3'd7)
                    begin
                        if (bytes_out >= decode_cfg.max_bytes)
                            halt_code = ST_LIMIT;
                        else
                        begin
                            bytes_out    = bytes_out + 8'd1;
                            r.kind       = KIND_DATA;
                            r.byte_value = shift_reg;
                            r.byte_total = bytes_out;
                            r.status     = ST_OK;
                            r.is_last    = 1'b0;
                            expected_results.push_back(r);
                            shift_reg = '0;
                            bits_in   = '0;
                        end
                    end
                    else
                        bits_in = bits_in + 3'd1;
                end
                else
                    halt_code = ST_BAD_PERIOD;
            end
        end
        held_high = s.d1;
        if (sym_count < MIN_SYMBOLS)
            sym_count = sym_count + 3'd1;

        if (s.last)
        begin
            r.kind       = KIND_END;
            r.byte_value = '0;
            r.is_last    = 1'b1;
            // A frame too short to carry a byte reports that alone.
            if (sym_count < MIN_SYMBOLS)
            begin
                r.byte_total = '0;
                r.status     = ST_SHORT;
            end
            else
            begin
                r.byte_total = bytes_out;
                r.status     = halt_code;
            end
            expected_results.push_back(r);
            sym_count = '0;
            held_high = '0;
            shift_reg = '0;
            bits_in   = '0;
            bytes_out = '0;
            halt_code = ST_OK;
        end
    endtask

    function automatic void check_field(string name, int unsigned exp_val,
                                        int unsigned act_val);
        if (exp_val != act_val)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, exp_val, act_val);
            fail_count++;
        end
    endfunction

    // Input prediction and output checking, both on the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            seen_sym.level = first_level;
            seen_sym.d0    = first_duration;
            seen_sym.d1    = second_duration;
            seen_sym.last  = frame_last;
            decode_symbol(seen_sym);
            accepted_count++;
        end
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $display({"%0t: unexpected result, expected none, actual kind %0d",
                          " value %0d total %0d status %0d last %0d"},
                         $time, kind, byte_value, byte_total, status, is_last);
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("kind", want.kind, kind);
                check_field("byte_value", want.byte_value, byte_value);
                check_field("byte_total", want.byte_total, byte_total);
                check_field("status", want.status, status);
                check_field("is_last", want.is_last, is_last);
            end
        end
    end

    // Symbol driver: a new transaction goes out only after the previous one
    // was accepted, after its random gap.
    int gap_left  = 0;
    bit in_steady = 1'b0;

    always @(negedge clk)
    begin
        if (rst_n && !(in_valid && accepted_count != issued_count))
        begin
            if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left--;
            end
            else if (symbol_backlog.size() != 0)
            begin
                seen_sym = symbol_backlog.pop_front();
                in_valid        <= 1'b1;
                first_level     <= seen_sym.level;
                first_duration  <= seen_sym.d0;
                second_duration <= seen_sym.d1;
                frame_last      <= seen_sym.last;
                issued_count++;
                if ($urandom_range(0, 149) == 0)
                    in_steady = !in_steady;
                gap_left = in_steady ? 0 : draw_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    int stall_left = 0;
    bit out_steady = 1'b0;

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 199) == 0)
                out_steady = !out_steady;
            stall_left = out_steady ? 0 : draw_gap();
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic add_sym(input logic level, input int d0, input int d1,
                           input logic last);
        pulse_sym_t s;
        s.level = level;
        s.d0    = DW'(d0);
        s.d1    = DW'(d1);
        s.last  = last;
        symbol_backlog.push_back(s);
        symbols_queued++;
        open_frame = !last;
    endtask

    // Mostly well-formed frames under the current windows; some are short,
    // some long and some carry one corrupted symbol.
    task automatic add_frame();
        pulse_sym_t frame[$];
        pulse_sym_t s;
        int n_sym, n_bits, pick, lo_lim, hi_lim, sum, hi_floor, hi_ceil, hi, k;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            n_sym = $urandom_range(1, 3);
        else if (pick > 96)
            n_sym = 2 + 8 * $urandom_range(5, 12);
        else
            n_sym = 2 + 8 * $urandom_range(0, 4) +
                    ((pick < 50) ? 0 : $urandom_range(1, 7));
        n_bits = (n_sym > 2) ? n_sym - 2 : 0;
        for (int i = 0; i < n_sym; i++)
        begin
            s.level = 1'($urandom_range(0, 1));
            s.d0    = DW'($urandom_range(0, DUR_MAX));
            s.d1    = DW'($urandom_range(0, DUR_MAX));
            s.last  = 1'b0;
            frame.push_back(s);
        end

        frame[0].level = 1'b0;
        lo_lim = int'(decode_cfg.preamble_min) + 1;
        hi_lim = int'(decode_cfg.preamble_max) - 1;
        if (lo_lim <= hi_lim)
            frame[0].d0 = DW'($urandom_range(lo_lim, hi_lim));

        lo_lim = int'(decode_cfg.period_min) + 1;
        hi_lim = int'(decode_cfg.period_max) - 1;
        if (hi_lim > 2 * DUR_MAX)
            hi_lim = 2 * DUR_MAX;
        for (int j = 0; j < n_bits; j++)
        begin
            if (lo_lim <= hi_lim)
            begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    sum = lo_lim;
                else if (pick == 1)
                    sum = hi_lim;
                else
                    sum = $urandom_range(lo_lim, hi_lim);
            end
            else
                sum = $urandom_range(0, 2 * DUR_MAX);
            hi_floor = (sum > DUR_MAX) ? sum - DUR_MAX : 0;
            hi_ceil  = (sum < DUR_MAX) ? sum : DUR_MAX;
            // Equal high and low times decode as a zero.
            if ($urandom_range(0, 9) == 0)
                hi = sum / 2;
            else
                hi = $urandom_range(hi_floor, hi_ceil);
            frame[j + 1].d1 = DW'(hi);
            frame[j + 2].d0 = DW'(sum - hi);
        end

        if ($urandom_range(0, 99) < 12)
        begin
            k = $urandom_range(0, n_sym - 1);
            frame[k].level = 1'($urandom_range(0, 1));
            frame[k].d0    = DW'($urandom_range(0, DUR_MAX));
        end
        frame[n_sym - 1].last = 1'b1;
        foreach (frame[i])
            add_sym(frame[i].level, frame[i].d0, frame[i].d1, frame[i].last);
    endtask

    task automatic run_random(input int n_items);
        int target;
        target = symbols_queued + n_items;
        while (symbols_queued < target)
        begin
            if ($urandom_range(0, 99) < 85)
                add_frame();
            else
                repeat ($urandom_range(1, 6))
                    add_sym(1'($urandom_range(0, 1)), $urandom_range(0, DUR_MAX),
                            $urandom_range(0, DUR_MAX), $urandom_range(0, 3) == 0);
        end
        if (open_frame)
            add_frame();
    endtask

    task automatic wait_idle();
        while (accepted_count != symbols_queued || expected_results.size() != 0)
            @(negedge clk);
        repeat (LATENCY) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        case (idx)
            REG_PREAMBLE_MIN: decode_cfg.preamble_min = value[14:0];
            REG_PREAMBLE_MAX: decode_cfg.preamble_max = value[14:0];
            REG_PERIOD_MIN:   decode_cfg.period_min   = value;
            REG_PERIOD_MAX:   decode_cfg.period_max   = value;
            REG_MAX_BYTES:    decode_cfg.max_bytes    = value[7:0];
            default: ;
        endcase
    endtask

    task automatic set_window(input int pre_lo, input int pre_hi, input int per_lo,
                              input int per_hi, input int byte_cap);
        write_reg(REG_PREAMBLE_MIN, CFG_DATA_W'(pre_lo));
        write_reg(REG_PREAMBLE_MAX, CFG_DATA_W'(pre_hi));
        write_reg(REG_PERIOD_MIN, CFG_DATA_W'(per_lo));
        write_reg(REG_PERIOD_MAX, CFG_DATA_W'(per_hi));
        write_reg(REG_MAX_BYTES, CFG_DATA_W'(byte_cap));
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    initial
    begin
        logic [7:0] pattern;
        int         pm, qm, qx;
        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_index = REG_PREAMBLE_MIN;
        cfg_data  = '0;
        decode_cfg.preamble_min = PREAMBLE_MIN_RESET;
        decode_cfg.preamble_max = PREAMBLE_MAX_RESET;
        decode_cfg.period_min   = PERIOD_MIN_RESET;
        decode_cfg.period_max   = PERIOD_MAX_RESET;
        decode_cfg.max_bytes    = MAX_BYTES_RESET;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Single-symbol frame: too short to report anything but that.
        add_sym(1'b0, 0, DUR_MAX, 1'b1);
        // Preamble at the right duration but high level.
        add_sym(1'b1, 2450, 900, 1'b0);
        add_sym(1'b0, DUR_MAX, DUR_MAX, 1'b0);
        add_sym(1'b1, 0, 0, 1'b0);
        add_sym(1'b0, 500, 400, 1'b1);
        // Preamble exactly on the lower bound is rejected.
        add_sym(1'b0, 2300, 100, 1'b0);
        add_sym(1'b1, 100, 500, 1'b0);
        add_sym(1'b0, 500, 0, 1'b0);
        add_sym(1'b0, DUR_MAX, 0, 1'b1);
        // A full byte completing on the last symbol: byte, then end report.
        pattern = 8'hA5;
        add_sym(1'b0, 2450, 123, 1'b0);
        add_sym(1'b1, 7, pattern[7] ? 700 : 450, 1'b0);
        for (int i = 7; i >= 0; i--)
            add_sym(1'b0, pattern[i] ? 200 : 450,
                    (i == 0) ? DUR_MAX : (pattern[i-1] ? 700 : 450), i == 0);
        // Period exactly on the upper bound stops decoding.
        add_sym(1'b0, 2599, 0, 1'b0);
        add_sym(1'b0, 0, 600, 1'b0);
        add_sym(1'b1, 500, 0, 1'b0);
        add_sym(1'b1, 100, DUR_MAX, 1'b1);

        run_random(300);
        wait_idle();

        set_window(1000, 1003, 30000, 65535, 2);
        run_random(300);
        wait_idle();

        // Widest windows with no byte allowed: the first byte hits the limit.
        set_window(0, DUR_MAX, 0, 65535, 0);
        run_random(250);
        wait_idle();

        // Empty windows: no preamble or period can pass.
        set_window(DUR_MAX, 0, 65535, 0, 255);
        run_random(200);
        wait_idle();

        repeat (4)
        begin
            pm = $urandom_range(0, 3000);
            qm = $urandom_range(0, 40000);
            qx = qm + $urandom_range(2, 20000);
            if (qx > 65535)
                qx = 65535;
            set_window(pm, pm + $urandom_range(2, 2000), qm, qx, $urandom_range(1, 6));
            run_random(100);
            wait_idle();
        end

        set_window(int'(PREAMBLE_MIN_RESET), int'(PREAMBLE_MAX_RESET),
                   int'(PERIOD_MIN_RESET), int'(PERIOD_MAX_RESET),
                   int'(MAX_BYTES_RESET));
        run_random(350);
        wait_idle();

        repeat (2 * LATENCY) @(posedge clk);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[sim.f]
design/opwfd_pkg.sv
design/opwfd_decode.sv
design/opwfd_result_fifo.sv
design/ook_pulse_width_frame_decoder.sv
dv/ook_pulse_width_frame_decoder_test.sv
